@@ hw/rtl/vse_pkg.sv @@
// ----------------------------------------------------------------------------
// vse_pkg
// Shared types and constants of the filled-ellipse span generator.
// ----------------------------------------------------------------------------
package vse_pkg;

  // vdu command codes
  localparam logic [7:0] CMD_CLS           = 8'd12;
  localparam logic [7:0] CMD_PLOT          = 8'd25;
  localparam logic [7:0] PLOT_FILL_ELLIPSE = 8'd157;

  localparam int N_PARAMS = 5;

  // configuration registers
  localparam int         ORIGIN_W     = 11;
  localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 11'd130;
  localparam logic [0:0] REG_ORIGIN_X = 1'b0;

  // geometry
  localparam int COORD_W = 16;
  localparam int SPAN_W  = COORD_W + 1;
  localparam int HALF_W  = 5;
  localparam int DY_W    = HALF_W + 2;
  localparam int ROOT_W  = HALF_W + 1;
  localparam int REM_W   = 2 * ROOT_W;
  localparam int STEP_W  = $clog2(ROOT_W);
  localparam logic [COORD_W-1:0] PY_BASE = 16'd255;

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

  typedef enum logic {
    KIND_SPAN  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [HALF_W-1:0]          half;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
  } job_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] row;
    logic [9:0] x_first;
    logic [9:0] x_last;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_ROW,
    BK_ROOT,
    BK_SPAN,
    BK_FLUSH
  } back_state_t;

  // parameter bytes wanted, keyed by the low five bits of a command
  function automatic logic [2:0] wanted_count(input logic [4:0] code);
    logic [2:0] n;
    unique case (code)
      5'd17:   n = 3'd1;
      5'd18:   n = 3'd2;
      5'd22:   n = 3'd1;
      5'd25:   n = 3'd5;
      5'd29:   n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/vdu_stream_filled_ellipse_spans.sv @@
// ----------------------------------------------------------------------------
// vdu_stream_filled_ellipse_spans
// VDU byte stream in, clear-screen and filled-ellipse row spans out.
// ----------------------------------------------------------------------------
// Input: one VDU byte per request, taken when push is high and full is low.
// Bytes are parsed as they are taken, so a byte stream runs at one byte a
// cycle while the job queue (two deep) has room. Only a clear or a filled
// ellipse PLOT makes a job; every other byte just updates parser state.
// Output: results wait in one output register; empty low means kind, row,
// x_first, x_last and last_of_run are valid, and pop takes them. While the
// output waits the span engine stalls and, once the job queue fills, so
// does the input side.
// Flow: a clear passes through the job queue to the span engine, which
// writes it to the output register. An ellipse is walked row by row, up to
// 2*MAX_HALF_AXIS+1 rows; each visible row takes a six-step square root and
// then a span step, which can wait while the output register is full.
// Reset (synchronous, rst high) clears parser state, cursor, queue and
// output; origin_x returns to 130. Configuration goes through the APB port,
// origin_x at address 0.
// ----------------------------------------------------------------------------
module vdu_stream_filled_ellipse_spans import vse_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 256,
  parameter int MAX_HALF_AXIS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  vdu_byte,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  row,
  output logic [9:0]  x_first,
  output logic [9:0]  x_last,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ORIGIN_W-1:0] origin_x;
  logic                cfg_write;
  logic                job_push;
  logic                job_pop;
  logic                job_full;
  logic                job_empty;
  job_t                job_in;
  job_t                job_out;
  result_t             res;

  // register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_ORIGIN_X) ? {{(32-ORIGIN_W){1'b0}}, origin_x} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= ORIGIN_RESET;
    end else if (cfg_write && (paddr[2] == REG_ORIGIN_X)) begin
      origin_x <= pwdata[ORIGIN_W-1:0];
    end
  end

  vse_front #(
    .MAX_HALF_AXIS (MAX_HALF_AXIS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .vdu_byte (vdu_byte),
    .origin_x (origin_x),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  vse_job_fifo u_job_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  vse_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (res)
  );

  assign kind        = res.kind;
  assign row         = res.row;
  assign x_first     = res.x_first;
  assign x_last      = res.x_last;
  assign last_of_run = res.last;

endmodule

@@ hw/rtl/vse_front.sv @@
// ----------------------------------------------------------------------------
// vse_front
// Command parser: collects parameter bytes, tracks the cursor and turns
// complete commands into jobs for the span engine.
// ----------------------------------------------------------------------------
module vse_front import vse_pkg::*; #(
  parameter int MAX_HALF_AXIS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          vdu_byte,
  input  logic [ORIGIN_W-1:0] origin_x,
  output logic                job_push,
  output job_t                job,
  input  logic                job_full
);

  logic [7:0]         current_command;
  logic [2:0]         params_received;
  logic [2:0]         params_wanted;
  logic [7:0]         param_store [N_PARAMS];
  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;

  logic [7:0]         current_command_next;
  logic [2:0]         params_received_next;
  logic [2:0]         params_wanted_next;
  logic               accept;
  logic               is_cls;
  logic               is_plot;
  logic [COORD_W-1:0] plot_x;
  logic [COORD_W-1:0] plot_y;
  logic signed [SPAN_W-1:0] diff;
  logic signed [SPAN_W-1:0] axis;
  logic [SPAN_W-1:0]  px_sum;

  assign full   = job_full;
  assign accept = push && !job_full;

  always_comb begin
    if (params_wanted != 3'd0) begin
      current_command_next = current_command;
      params_received_next = params_received + 3'd1;
      params_wanted_next   = params_wanted - 3'd1;
    end else begin
      current_command_next = vdu_byte;
      params_received_next = 3'd0;
      params_wanted_next   = wanted_count(vdu_byte[4:0]);
    end
  end

  assign is_cls  = (params_wanted_next == 3'd0) && (current_command_next == CMD_CLS);
  assign is_plot = (params_wanted_next == 3'd0) && (current_command_next == CMD_PLOT);

  // a plot completes on its fifth parameter, which is the byte on the port
  assign plot_x = {param_store[2], param_store[1]};
  assign plot_y = {vdu_byte, param_store[3]};

  assign diff   = $signed({plot_x[COORD_W-1], plot_x}) - $signed({cursor_x[COORD_W-1], cursor_x});
  assign axis   = diff >>> 2;
  assign px_sum = {cursor_x[COORD_W-1], cursor_x} + {{(SPAN_W-ORIGIN_W){1'b0}}, origin_x};

  always_comb begin
    job.kind = is_cls ? KIND_CLEAR : KIND_SPAN;
    job.half = (axis[COORD_W-1:0] > COORD_W'(MAX_HALF_AXIS)) ? HALF_W'(MAX_HALF_AXIS)
                                                              : axis[HALF_W-1:0];
    job.px   = $signed(px_sum[SPAN_W-1:1]);
    job.py   = $signed(PY_BASE - {{2{cursor_y[COORD_W-1]}}, cursor_y[COORD_W-1:2]});
  end

  // negative half-axis draws nothing
  assign job_push = accept &&
                    (is_cls || (is_plot && (param_store[0] == PLOT_FILL_ELLIPSE) &&
                                !axis[SPAN_W-1]));

  always_ff @(posedge clk) begin
    if (rst) begin
      current_command <= '0;
      params_received <= '0;
      params_wanted   <= '0;
      cursor_x        <= '0;
      cursor_y        <= '0;
    end else if (accept) begin
      current_command <= current_command_next;
      params_received <= params_received_next;
      params_wanted   <= params_wanted_next;
      if (is_plot) begin
        cursor_x <= plot_x;
        cursor_y <= plot_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (params_wanted != 3'd0) && (params_received < 3'(N_PARAMS))) begin
      param_store[params_received] <= vdu_byte;
    end
  end

endmodule

@@ hw/rtl/vse_job_fifo.sv @@
// ----------------------------------------------------------------------------
// vse_job_fifo
// Short job queue between the command parser and the span engine.
// ----------------------------------------------------------------------------
module vse_job_fifo import vse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic empty
);

  job_t                 entries [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr;
  logic [JOB_PTR_W-1:0] rd_ptr;
  logic [JOB_PTR_W:0]   count;

  assign full    = (count == (JOB_PTR_W+1)'(JOB_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/vse_back.sv @@
// ----------------------------------------------------------------------------
// vse_back
// Span engine: walks the rows of an ellipse, finds each half-width with a
// bit-serial square root, clips it and hands spans to the output register.
// ----------------------------------------------------------------------------
module vse_back import vse_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_empty,
  input  job_t    job,
  output logic    job_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  back_state_t               state;
  back_state_t               state_next;
  logic [HALF_W-1:0]         half;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [DY_W-1:0]    dy;
  logic [REM_W-1:0]          rem;
  logic [ROOT_W-1:0]         root;
  logic [STEP_W-1:0]         step;
  result_t                   pend;
  logic                      pend_valid;
  result_t                   out_reg;
  logic                      out_valid;

  logic                      load_job;
  logic                      advance;
  logic                      start_root;
  logic                      root_step;
  logic                      take_span;
  logic                      emit_pend;
  logic                      emit_last;
  logic                      emit_clear;

  logic                      out_free;
  logic signed [SPAN_W-1:0]  row_full;
  logic                      row_ok;
  logic                      last_row;
  logic [DY_W-1:0]           dy_abs;
  logic [2*HALF_W-1:0]       b_sq;
  logic [2*HALF_W-1:0]       dy_sq;
  logic [REM_W-1:0]          rem_calc;
  logic [ROOT_W-1:0]         trial;
  logic [REM_W-1:0]          trial_sq;
  logic [REM_W-1:0]          root_sq;
  logic [ROOT_W-1:0]         two_b;
  logic [ROOT_W-1:0]         d;
  logic signed [SPAN_W-1:0]  lo_full;
  logic signed [SPAN_W-1:0]  hi_full;
  logic signed [SPAN_W-1:0]  lo_c;
  logic signed [SPAN_W-1:0]  hi_c;
  logic                      span_ok;
  result_t                   span_res;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign result   = out_reg;

  // row test
  assign row_full = $signed({py[COORD_W-1], py}) +
                    $signed({{(SPAN_W-DY_W){dy[DY_W-1]}}, dy});
  assign row_ok   = !row_full[SPAN_W-1] && (row_full < $signed(SPAN_W'(SCREEN_HEIGHT)));
  assign last_row = (dy == $signed({2'b00, half}));

  // remaining budget 4b^2 + 2 - 4dy^2, always at least 2
  assign dy_abs   = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
  assign b_sq     = half * half;
  assign dy_sq    = dy_abs[HALF_W-1:0] * dy_abs[HALF_W-1:0];
  assign rem_calc = {b_sq, 2'b00} + REM_W'(2) - {dy_sq, 2'b00};

  // one root bit per cycle, msb first
  assign trial    = root | (ROOT_W'(1) << step);
  assign trial_sq = trial * trial;
  assign root_sq  = root * root;

  // half-width is the root, but never beyond 2b
  assign two_b   = {half, 1'b0};
  assign d       = (root > two_b) ? two_b : root;
  assign lo_full = $signed({px[COORD_W-1], px}) - $signed({{(SPAN_W-ROOT_W){1'b0}}, d});
  assign hi_full = $signed({px[COORD_W-1], px}) + $signed({{(SPAN_W-ROOT_W){1'b0}}, d});
  assign lo_c    = lo_full[SPAN_W-1] ? '0 : lo_full;
  assign hi_c    = (!hi_full[SPAN_W-1] && (hi_full > $signed(SPAN_W'(SCREEN_WIDTH-1))))
                   ? $signed(SPAN_W'(SCREEN_WIDTH-1)) : hi_full;
  assign span_ok = (lo_c <= hi_c);

  always_comb begin
    span_res.kind    = KIND_SPAN;
    span_res.row     = row_full[7:0];
    span_res.x_first = lo_c[9:0];
    span_res.x_last  = hi_c[9:0];
    span_res.last    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    load_job   = 1'b0;
    advance    = 1'b0;
    start_root = 1'b0;
    root_step  = 1'b0;
    take_span  = 1'b0;
    emit_pend  = 1'b0;
    emit_last  = 1'b0;
    emit_clear = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          load_job   = 1'b1;
          state_next = (job.kind == KIND_CLEAR) ? BK_CLEAR : BK_ROW;
        end
      end
      BK_CLEAR: begin
        if (out_free) begin
          emit_clear = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_ROW: begin
        if (row_ok) begin
          start_root = 1'b1;
          state_next = BK_ROOT;
        end else if (last_row) begin
          state_next = BK_FLUSH;
        end else begin
          advance = 1'b1;
        end
      end
      BK_ROOT: begin
        root_step = 1'b1;
        if (step == '0) begin
          state_next = BK_SPAN;
        end
      end
      BK_SPAN: begin
        // a span is held back one place so the final one can carry the last flag
        if (!span_ok || !pend_valid || out_free) begin
          take_span = span_ok;
          emit_pend = span_ok && pend_valid;
          if (last_row) begin
            state_next = BK_FLUSH;
          end else begin
            advance    = 1'b1;
            state_next = BK_ROW;
          end
        end
      end
      BK_FLUSH: begin
        if (!pend_valid) begin
          state_next = BK_IDLE;
        end else if (out_free) begin
          emit_pend  = 1'b1;
          emit_last  = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      half <= job.half;
      px   <= job.px;
      py   <= job.py;
      dy   <= -$signed({2'b00, job.half});
    end else if (advance) begin
      dy <= dy + DY_W'(1);
    end
    if (start_root) begin
      rem  <= rem_calc;
      root <= '0;
      step <= STEP_W'(ROOT_W-1);
    end else if (root_step) begin
      if (trial_sq <= rem) begin
        root <= trial;
      end
      step <= step - 1'b1;
    end
    if (take_span) begin
      pend <= span_res;
    end
    if (emit_clear) begin
      out_reg.kind    <= KIND_CLEAR;
      out_reg.row     <= '0;
      out_reg.x_first <= '0;
      out_reg.x_last  <= '0;
      out_reg.last    <= 1'b1;
    end else if (emit_pend) begin
      out_reg <= '{kind: pend.kind, row: pend.row, x_first: pend.x_first,
                   x_last: pend.x_last, last: emit_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take_span) begin
        pend_valid <= 1'b1;
      end else if (emit_last) begin
        pend_valid <= 1'b0;
      end
      if (emit_clear || emit_pend) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pend_flushed: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state != BK_IDLE))
    else $error("held span left behind at end of job");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_ROOT) |-> (root_sq <= rem))
    else $error("partial root exceeds remaining budget");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(out_reg)))
    else $error("waiting result overwritten");

  a_clear_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_reg.kind == KIND_CLEAR)) |-> out_reg.last)
    else $error("clear result without last flag");

endmodule

@@ test/vdu_stream_filled_ellipse_spans_checker.sv @@
// ----------------------------------------------------------------------------
// vdu_stream_filled_ellipse_spans_checker
// Watches the byte, result and APB channels of the ellipse span generator,
// keeps its own parser, cursor and origin, and compares every popped result
// with the oldest predicted one. Hands back a failure count and the number
// of results still owed.
// ----------------------------------------------------------------------------
module vdu_stream_filled_ellipse_spans_checker import vse_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 256,
  parameter int MAX_HALF_AXIS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  vdu_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic        kind,
  input  logic [7:0]  row,
  input  logic [9:0]  x_first,
  input  logic [9:0]  x_last,
  input  logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ORIGIN_ADDR = 3'({REG_ORIGIN_X, 2'b00});

  logic [ORIGIN_W-1:0] origin_x_model;
  logic [7:0]          command;
  logic [2:0]          bytes_got;
  logic [2:0]          bytes_owed;
  logic [7:0]          plot_args [N_PARAMS];
  logic [15:0]         cursor_x;
  logic [15:0]         cursor_y;
  result_t             pending_spans [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endfunction

  // parameter bytes a command collects, keyed by its low five bits
  function automatic logic [2:0] params_for(input logic [7:0] cmd);
    case (cmd[4:0]) inside
      5'd17, 5'd22: return 3'd1;
      5'd18:        return 3'd2;
      5'd25:        return 3'd5;
      5'd29:        return 3'd4;
      default:      return 3'd0;
    endcase
  endfunction

  // at most one span per visible row, top to bottom, centred on the old cursor
  function automatic void draw_filled_ellipse(input logic [15:0] end_x);
    int      cx, cy, b, px, py, bound, dy, line, rem, d, lo, hi;
    result_t span;
    cx = $signed(cursor_x);
    cy = $signed(cursor_y);
    b  = ($signed(end_x) - cx) >>> 2;
    if (b < 0) return;
    if (b > MAX_HALF_AXIS) b = MAX_HALF_AXIS;
    px    = (cx + int'(origin_x_model)) >>> 1;
    py    = int'(PY_BASE) - (cy >>> 2);
    bound = 4 * b * b + 2;
    for (dy = -b; dy <= b; dy++) begin
      line = py + dy;
      if (line < 0 || line >= SCREEN_HEIGHT) continue;
      rem = bound - 4 * dy * dy;
      d   = 2 * b;
      while (d > 0 && d * d > rem) d--;
      lo = px - d;
      hi = px + d;
      if (lo < 0) lo = 0;
      if (hi > SCREEN_WIDTH - 1) hi = SCREEN_WIDTH - 1;
      if (lo > hi) continue;
      span.kind    = KIND_SPAN;
      span.row     = 8'(line);
      span.x_first = 10'(lo);
      span.x_last  = 10'(hi);
      span.last    = 1'b0;
      pending_spans.push_back(span);
    end
  endfunction

  function automatic void take_byte(input logic [7:0] value);
    result_t cls_result;
    int      queued_earlier;
    queued_earlier = pending_spans.size();
    if (bytes_owed != 0) begin
      if (bytes_got < N_PARAMS) plot_args[bytes_got] = value;
      bytes_got  = bytes_got + 3'd1;
      bytes_owed = bytes_owed - 3'd1;
    end else begin
      command    = value;
      bytes_got  = '0;
      bytes_owed = params_for(value);
    end
    if (bytes_owed == 0) begin
      if (command == CMD_CLS) begin
        cls_result = '{KIND_CLEAR, 8'd0, 10'd0, 10'd0, 1'b0};
        pending_spans.push_back(cls_result);
      end else if (command == CMD_PLOT) begin
        if (plot_args[0] == PLOT_FILL_ELLIPSE) draw_filled_ellipse({plot_args[2], plot_args[1]});
        cursor_x = {plot_args[2], plot_args[1]};
        cursor_y = {plot_args[4], plot_args[3]};
      end
    end
    if (pending_spans.size() > queued_earlier)
      pending_spans[pending_spans.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      origin_x_model = ORIGIN_RESET;
      command        = '0;
      bytes_got      = '0;
      bytes_owed     = '0;
      cursor_x       = '0;
      cursor_y       = '0;
      pending_spans.delete();
    end else begin
      if (psel && penable && pready && paddr == ORIGIN_ADDR) begin
        if (pwrite) begin
          origin_x_model = pwdata[ORIGIN_W-1:0];
        end else if (prdata !== 32'(origin_x_model)) begin
          log_failure($sformatf("origin_x read: expected %0d, got %0d", origin_x_model, prdata));
        end
      end
      if (push && !full) take_byte(vdu_byte);
      if (pop && !empty) begin
        got = '{kind_t'(kind), row, x_first, x_last, last_of_run};
        if (pending_spans.size() == 0) begin
          log_failure($sformatf("unexpected result: kind %0d row %0d x %0d..%0d last %0d",
                                kind, row, x_first, x_last, last_of_run));
        end else begin
          want = pending_spans.pop_front();
          if (got !== want)
            log_failure($sformatf({"result mismatch: expected kind %0d row %0d x %0d..%0d ",
                                   "last %0d, got kind %0d row %0d x %0d..%0d last %0d"},
                                  want.kind, want.row, want.x_first, want.x_last, want.last,
                                  kind, row, x_first, x_last, last_of_run));
        end
      end
    end
    pending = pending_spans.size();
  end

endmodule

@@ test/vdu_stream_filled_ellipse_spans_test.sv @@
// ----------------------------------------------------------------------------
// vdu_stream_filled_ellipse_spans_test
// Drives VDU byte streams into the ellipse span generator: a short directed
// run through clears, aliased commands and ellipse corner cases, then three
// random batches under different origin settings and idling patterns. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module vdu_stream_filled_ellipse_spans_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vse_pkg::*;

  localparam int         CYCLE_LIMIT   = 2_000_000;
  localparam int         SETTLE_CYCLES = 1200;
  localparam int         BATCH_BYTES   = 115;
  localparam logic [2:0] ORIGIN_ADDR   = 3'({REG_ORIGIN_X, 2'b00});
  localparam logic [2:0] SPARE_ADDR    = 3'd4;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        push     = 1'b0;
  logic [7:0]  vdu_byte = '0;
  logic        pop      = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic        full, empty, kind, last_of_run, pready;
  logic [7:0]  row;
  logic [9:0]  x_first, x_last;
  logic [31:0] prdata;

  int          fail_count, pending;
  int          cycles        = 0;
  int          bytes_sent    = 0;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 88;
  logic [15:0] pen_x         = '0;

  vdu_stream_filled_ellipse_spans u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .vdu_byte(vdu_byte),
    .empty(empty), .pop(pop), .kind(kind), .row(row), .x_first(x_first),
    .x_last(x_last), .last_of_run(last_of_run), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vdu_stream_filled_ellipse_spans_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .vdu_byte(vdu_byte),
    .empty(empty), .pop(pop), .kind(kind), .row(row), .x_first(x_first),
    .x_last(x_last), .last_of_run(last_of_run), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) pop <= !rst && ($urandom_range(99) >= recv_idle_pct);

  // push stays high across back-to-back requests; it only drops for a gap
  task automatic send_byte(input logic [7:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push     <= 1'b1;
    vdu_byte <= value;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_plot(input logic [7:0] code, input logic [15:0] x, input logic [15:0] y);
    send_byte(CMD_PLOT);
    send_byte(code);
    send_byte(x[7:0]);
    send_byte(x[15:8]);
    send_byte(y[7:0]);
    send_byte(y[15:8]);
    pen_x = x;
  endtask

  // hold off until every predicted result is out, then let a silent ellipse finish
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic is_write, input logic [2:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_origin(input logic [ORIGIN_W-1:0] value);
    drain();
    apb_access(1'b1, SPARE_ADDR, $urandom);
    apb_access(1'b1, ORIGIN_ADDR, 32'(value));
    apb_access(1'b0, ORIGIN_ADDR, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_sequence();
    int          pick;
    int          count;
    logic [4:0]  code;
    logic [15:0] x, y;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // move the cursor somewhere, often well off screen
      x = 16'($urandom_range(2600)) - 16'd1100;
      y = 16'($urandom_range(1500)) - 16'd200;
      if ($urandom_range(9) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      send_plot(8'($urandom), x, y);
    end else if (pick < 60) begin
      // half-axis mostly small, sometimes negative or beyond saturation
      x = pen_x + 16'($urandom_range(170)) - 16'd30;
      y = 16'($urandom_range(1500)) - 16'd200;
      if ($urandom_range(9) == 0) x = 16'($urandom);
      send_plot(($urandom_range(9) < 8) ? PLOT_FILL_ELLIPSE : 8'($urandom), x, y);
    end else if (pick < 72) begin
      send_byte(CMD_CLS);
    end else if (pick < 84) begin
      case ($urandom_range(4))
        0:       begin code = 5'd17; count = 1; end
        1:       begin code = 5'd18; count = 2; end
        2:       begin code = 5'd22; count = 1; end
        3:       begin code = 5'd25; count = 5; end
        default: begin code = 5'd29; count = 4; end
      endcase
      send_byte({3'($urandom), code});
      repeat (count) send_byte(8'($urandom));
    end else if (pick < 92) begin
      // plot cut short, so the next command byte lands in its arguments
      send_byte(CMD_PLOT);
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end
  endtask

  task automatic random_batch();
    int target;
    target = bytes_sent + BATCH_BYTES;
    while (bytes_sent < target) random_sequence();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_byte(CMD_CLS);
    send_byte(CMD_CLS | 8'h80);
    // lower rows fall off the bottom of the screen
    send_plot(PLOT_FILL_ELLIPSE, 16'd40, 16'd512);
    // half-axis saturates
    send_plot(PLOT_FILL_ELLIPSE, 16'd240, 16'hFFF0);
    // negative half-axis, cursor still moves
    send_plot(PLOT_FILL_ELLIPSE, 16'd0, 16'd256);
    // aliased plot collects five bytes and does nothing
    send_byte(CMD_PLOT | 8'h20);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);

    set_origin('0);
    random_batch();

    set_origin('1);
    send_idle_pct = 88;
    recv_idle_pct = 35;
    random_batch();

    set_origin(ORIGIN_W'($urandom_range(1279)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_batch();

    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/vse_pkg.sv
hw/rtl/vse_front.sv
hw/rtl/vse_job_fifo.sv
hw/rtl/vse_back.sv
hw/rtl/vdu_stream_filled_ellipse_spans.sv
test/vdu_stream_filled_ellipse_spans_checker.sv
test/vdu_stream_filled_ellipse_spans_test.sv
